// ===== rtl/core/cxr_pkg.sv =====
package cxr_pkg;

   localparam int FRACTION_BITS = 20;
   localparam int GT_INDEX_BITS = 10;
   localparam int ROOT_BITS     = 30;

   // Q4.F quotient word and the widths around the matrix.
   localparam int QW      = FRACTION_BITS + 4;
   localparam int TW      = FRACTION_BITS + 22;
   localparam int RW      = TW + QW;
   localparam int COEF_W  = FRACTION_BITS + 2;
   localparam int CZ_W    = 18;
   localparam int PW      = COEF_W + CZ_W;
   localparam int GW      = FRACTION_BITS + 2;

   localparam int GT_ENTRIES = (1 << GT_INDEX_BITS) + 1;
   localparam int DIV_LAT    = QW + 1;
   localparam int FRONT_LAT  = 4;
   localparam int GAMMA_LAT  = 5;
   localparam int PIPE_LAT   = FRONT_LAT + DIV_LAT + GAMMA_LAT;

   localparam logic signed [COEF_W-1:0] COEF_Q [9] = '{
      COEF_W'(((longint'(1656492) << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(354851)  << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(255038)  << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(707196)  << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(1655397) << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(36152)   << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(51713)   << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(121364)  << FRACTION_BITS) + 64'sd500000) / 1000000),
      COEF_W'(((longint'(1011530) << FRACTION_BITS) + 64'sd500000) / 1000000)
   };

   localparam logic signed [QW-1:0] LIN_LIMIT =
      QW'(((longint'(31308) << FRACTION_BITS) + 64'sd5000000) / 10000000);

   // Division by ten through a reciprocal multiply.
   localparam int LPW       = FRACTION_BITS + 8;
   localparam int DIV10_SH  = LPW + 4;
   localparam int MULW      = DIV10_SH - 3;
   localparam logic [MULW-1:0] DIV10_MUL = MULW'((longint'(1) << DIV10_SH) / 10 + 1);

   typedef struct packed {
      logic [TW-1:0] mag;
      logic [TW-1:0] den;
      logic          neg;
      logic          norm;
   } div_req_type;

   function automatic longint unsigned mul30(input longint unsigned a,
                                             input longint unsigned b);
      return (a * b) >> ROOT_BITS;
   endfunction

   // Gamma curve entry: 1.055*u^(5/12) - 0.055 at u = idx / 2^B, in Q.F.
   function automatic longint gamma_entry(input int idx);
      longint unsigned u, w, lo, hi, mid, r2, r4, r8, u2, u4;
      longint g30;
      u  = longint'(idx) << (ROOT_BITS - GT_INDEX_BITS);
      u2 = mul30(u, u);
      u4 = mul30(u2, u2);
      w  = mul30(u4, u);
      lo = 0;
      hi = longint'(1) << ROOT_BITS;
      for (int n = 0; n < 40; n++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            r2  = mul30(mid, mid);
            r4  = mul30(r2, r2);
            r8  = mul30(r4, r4);
            if (mul30(r8, r4) <= w) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      g30 = longint'((lo * 1055) / 1000) - 64'sd59055800;
      if (g30 < 0) begin
         return -((-g30) >>> (ROOT_BITS - FRACTION_BITS));
      end
      return g30 >>> (ROOT_BITS - FRACTION_BITS);
   endfunction

endpackage

// ===== rtl/core/cie_xy_to_rgb_converter.sv =====
// CIE xy chromaticity to 8-bit RGB converter.
// An input transfer on the req channel carries color_x and color_y (unsigned
// fractions scaled by 65536). The block forms the wide-gamut D65 matrix product,
// normalizes by the strictly largest component when it exceeds one, applies the
// sRGB gamma curve and returns red, green and blue bytes on the rsp channel.
// A zero y gives all-zero bytes with rsp_tuser set.
// The datapath is a 34-stage pipeline: four stages for the matrix and the
// selection of the divisor, 25 stages of a bit-per-stage divider (one per
// channel, running side by side) and five stages of gamma and byte logic.
// One item can be taken in every cycle while rsp is not stalled, so the sustained
// rate is one item per cycle whenever the receiver keeps taking results.
// The whole pipeline advances while the output register is empty or being read;
// when the receiver holds rsp_tready low with a result waiting, every stage
// holds its contents and req_tready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the gamma table is constant logic and
// needs no clearing.
module cie_xy_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // color_x [15:0], color_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_level [7:0], green_level [15:8], blue_level [23:16]
   output logic        rsp_tuser    // zero_y_flag [0]
);

   localparam int FB  = cxr_pkg::FRACTION_BITS;
   localparam int TW  = cxr_pkg::TW;
   localparam int PW  = cxr_pkg::PW;
   localparam int CZW = cxr_pkg::CZ_W;
   localparam int LAT = cxr_pkg::PIPE_LAT;

   // Global advance: the pipeline moves when the output slot is free or drained.
   logic adv;

   logic [LAT-1:0] vld_ff, vld_in;
   logic [LAT-1:0] zero_ff, zero_in;

   // Stage 1: operands x, y and z = 1 - x - y, all at scale 2^16.
   logic signed [CZW-1:0] opd_ff [3];
   logic signed [CZW-1:0] cx_w, cy_w, cz_w;
   logic [15:0]           cy1_ff, cy2_ff, cy3_ff;

   // Stage 2: the nine matrix products.
   logic signed [PW-1:0] p_ff [9];
   logic signed [PW-1:0] p_in [9];

   // Stage 3: matrix rows summed exactly.
   logic signed [TW-1:0] tr_ff, tg_ff, tb_ff;
   logic signed [TW-1:0] lim;

   // Stage 4: divisor choice and magnitudes for the three dividers.
   logic r_top, g_top, b_top;
   cxr_pkg::div_req_type rq_ff [3];
   cxr_pkg::div_req_type rq_in [3];
   logic [TW-1:0] den_sel;

   logic signed [cxr_pkg::QW-1:0] quot [3];
   logic [7:0] level [3];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign vld_in  = {vld_ff[LAT-2:0], req_tvalid};
   assign zero_in = {zero_ff[LAT-2:0], req_tdata[31:16] == 16'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= zero_in;
      end
   end

   assign cx_w = $signed({2'b00, req_tdata[15:0]});
   assign cy_w = $signed({2'b00, req_tdata[31:16]});
   assign cz_w = CZW'(65536) - cx_w - cy_w;

   for (genvar i = 0; i < 9; i++) begin : g_prod
      assign p_in[i] = $signed(cxr_pkg::COEF_Q[i]) * opd_ff[i % 3];
   end

   assign lim = $signed(TW'({cy3_ff, {FB{1'b0}}}));

   assign r_top = (tr_ff > tb_ff) && (tr_ff > tg_ff) && (tr_ff > lim);
   assign g_top = (tg_ff > tb_ff) && (tg_ff > tr_ff) && (tg_ff > lim);
   assign b_top = (tb_ff > tr_ff) && (tb_ff > tg_ff) && (tb_ff > lim);

   always_comb begin
      if (r_top) begin
         den_sel = tr_ff;
      end else if (g_top) begin
         den_sel = tg_ff;
      end else if (b_top) begin
         den_sel = tb_ff;
      end else begin
         den_sel = TW'(cy3_ff);
      end
   end

   always_comb begin
      rq_in[0].mag = tr_ff[TW-1] ? TW'(-tr_ff) : tr_ff;
      rq_in[0].neg = tr_ff[TW-1];
      rq_in[1].mag = tg_ff[TW-1] ? TW'(-tg_ff) : tg_ff;
      rq_in[1].neg = tg_ff[TW-1];
      rq_in[2].mag = tb_ff[TW-1] ? TW'(-tb_ff) : tb_ff;
      rq_in[2].neg = tb_ff[TW-1];
      for (int c = 0; c < 3; c++) begin
         rq_in[c].den  = den_sel;
         rq_in[c].norm = r_top || g_top || b_top;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opd_ff[0] <= cx_w;
         opd_ff[1] <= cy_w;
         opd_ff[2] <= cz_w;
         cy1_ff    <= req_tdata[31:16];

         p_ff      <= p_in;
         cy2_ff    <= cy1_ff;

         tr_ff     <=  TW'(p_ff[0]) - TW'(p_ff[1]) - TW'(p_ff[2]);
         tg_ff     <= -TW'(p_ff[3]) + TW'(p_ff[4]) + TW'(p_ff[5]);
         tb_ff     <=  TW'(p_ff[6]) - TW'(p_ff[7]) + TW'(p_ff[8]);
         cy3_ff    <= cy2_ff;

         rq_ff     <= rq_in;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      cxr_div u_div (
         .clock (clock),
         .en    (adv),
         .req   (rq_ff[c]),
         .quot  (quot[c])
      );
      cxr_gamma u_gamma (
         .clock (clock),
         .en    (adv),
         .v     (quot[c]),
         .level (level[c])
      );
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tuser  = zero_ff[LAT-1];
   assign rsp_tdata  = zero_ff[LAT-1] ? 24'd0 : {level[2], level[1], level[0]};

`ifndef SYNTH
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("zero y result carries nonzero levels");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_zero_in: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[31:16] == 16'd0 |=> vld_ff[0] && zero_ff[0])
      else $error("zero y input not tagged on entry");
`endif

endmodule

// ===== rtl/core/cxr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating to Q4.F.
module cxr_div (
   input  logic                        clock,
   input  logic                        en,
   input  cxr_pkg::div_req_type        req,
   output logic signed [cxr_pkg::QW-1:0] quot
);

   localparam int QW = cxr_pkg::QW;
   localparam int RW = cxr_pkg::RW;
   localparam int TW = cxr_pkg::TW;

   logic [RW-1:0] rem_ff [QW-1];
   logic [TW-1:0] dv_ff  [QW-1];
   logic [QW-2:0] q_ff   [QW];
   logic          neg_ff [QW];
   logic          sat_ff [QW];
   logic signed [QW-1:0] quot_ff;
   logic [RW-1:0] num_w;

   assign num_w = req.norm ? (RW'(req.mag) << cxr_pkg::FRACTION_BITS) : RW'(req.mag);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_w;
         dv_ff[0]  <= req.den;
         q_ff[0]   <= '0;
         neg_ff[0] <= req.neg;
         sat_ff[0] <= num_w >= (RW'(req.den) << (QW - 1));
      end
   end

   for (genvar k = 1; k < QW; k++) begin : g_step
      localparam int Bit = QW - 1 - k;
      logic [RW-1:0] dsh;
      logic          take;
      assign dsh  = RW'(dv_ff[k-1]) << Bit;
      assign take = rem_ff[k-1] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= q_ff[k-1] | ((QW-1)'(take) << Bit);
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
      if (k < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? rem_ff[k-1] - dsh : rem_ff[k-1];
               dv_ff[k]  <= dv_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (sat_ff[QW-1]) begin
            quot_ff <= neg_ff[QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
         end else if (neg_ff[QW-1]) begin
            quot_ff <= -$signed({1'b0, q_ff[QW-1]});
         end else begin
            quot_ff <= $signed({1'b0, q_ff[QW-1]});
         end
      end
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/core/cxr_gamma.sv =====
// sRGB transfer curve and byte conversion, five register stages.
module cxr_gamma (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [cxr_pkg::QW-1:0] v,
   output logic [7:0]                    level
);

   localparam int FB   = cxr_pkg::FRACTION_BITS;
   localparam int GB   = cxr_pkg::GT_INDEX_BITS;
   localparam int GW   = cxr_pkg::GW;
   localparam int FL   = FB - GB;
   localparam int LVW  = FB - 8;
   localparam int LPW  = cxr_pkg::LPW;
   localparam int LQW  = LPW + cxr_pkg::MULW;
   localparam int PRW  = GW + FL + 2;
   localparam int SW   = FB + 10;
   localparam logic signed [SW-1:0] S_FULL = SW'(longint'(255) << FB);
   localparam logic signed [SW-1:0] HALF   = SW'(longint'(1) << (FB - 1));
   localparam logic signed [SW-1:0] S_HI   = S_FULL - HALF;
   localparam logic signed [cxr_pkg::QW-1:0] ONE_Q = cxr_pkg::QW'(longint'(1) << FB);

   typedef enum logic [1:0] {CL_ZERO, CL_ONE, CL_LIN, CL_INT} cls_type;

   logic signed [GW-1:0] tab [cxr_pkg::GT_ENTRIES];

   for (genvar i = 0; i < cxr_pkg::GT_ENTRIES; i++) begin : g_tab
      localparam longint Entry = cxr_pkg::gamma_entry(i);
      assign tab[i] = GW'(Entry);
   end

   cls_type cls_in, cls1_ff, cls2_ff, cls3_ff;
   logic [LPW-1:0]       lp_ff;
   logic [GB:0]          idx_ff;
   logic [FL-1:0]        fl1_ff, fl2_ff;
   logic [LQW-1:0]       lq_ff;
   logic signed [GW-1:0] lo2_ff, hi2_ff, lo3_ff;
   logic [LPW-1:0]       sl_ff;
   logic signed [PRW-1:0] prod_ff;
   logic signed [SW-1:0] s_ff, s_in;
   logic signed [GW:0]   val;
   logic [7:0]           level_ff;

   always_comb begin
      if (v <= cxr_pkg::LIN_LIMIT) begin
         cls_in = (v <= 0) ? CL_ZERO : CL_LIN;
      end else begin
         cls_in = (v >= ONE_Q) ? CL_ONE : CL_INT;
      end
   end

   assign val = (GW+1)'(lo3_ff) + (GW+1)'(prod_ff >>> FL);

   always_comb begin
      case (cls3_ff)
         CL_ZERO: s_in = '0;
         CL_ONE:  s_in = S_FULL;
         CL_LIN:  s_in = SW'(sl_ff);
         default: s_in = (SW'(val) <<< 8) - SW'(val);
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls1_ff  <= cls_in;
         lp_ff    <= LPW'(v[LVW-1:0]) * LPW'(16'd32946);
         idx_ff   <= {1'b0, v[FB-1:FL]};
         fl1_ff   <= v[FL-1:0];

         cls2_ff  <= cls1_ff;
         lq_ff    <= LQW'(lp_ff) * LQW'(cxr_pkg::DIV10_MUL);
         lo2_ff   <= tab[idx_ff];
         hi2_ff   <= tab[idx_ff + 1'b1];
         fl2_ff   <= fl1_ff;

         cls3_ff  <= cls2_ff;
         sl_ff    <= lq_ff[cxr_pkg::DIV10_SH +: LPW];
         lo3_ff   <= lo2_ff;
         prod_ff  <= PRW'($signed({hi2_ff[GW-1], hi2_ff} - {lo2_ff[GW-1], lo2_ff}))
                     * PRW'($signed({1'b0, fl2_ff}));

         s_ff     <= s_in;

         if (s_ff > S_HI) begin
            level_ff <= 8'hFF;
         end else if (s_ff < HALF) begin
            level_ff <= 8'h00;
         end else begin
            level_ff <= s_ff[FB +: 8];
         end
      end
   end

   assign level = level_ff;

endmodule
